FILE: hw/rtl/btndb_pkg.sv
// Package for the five-button debouncer with short and long press detection.
// Holds the button state encoding, operation and register codes, and the
// control structs shared by the top level and the per-button cell.
package btndb_pkg;

    localparam int PIN_BITS      = 5;
    localparam int OUT_BUTTONS   = 5;
    localparam int STATE_W       = 3;
    localparam int COUNT_W       = 8;
    localparam int TIMER_W       = 8;
    localparam int CFG_DATA_W    = 8;
    localparam int CFG_INDEX_W   = 1;
    localparam int IDX_W         = 3;
    localparam int IDX_CMP_W     = 6;

    localparam logic [TIMER_W-1:0] INITIAL_DELAY      = 8'h05;
    localparam logic [TIMER_W-1:0] RESET_DEBOUNCE     = 8'h05;
    localparam logic [COUNT_W-1:0] RESET_LONG_FACTOR  = 8'h0A;
    localparam logic [COUNT_W-1:0] COUNT_MAX          = 8'hFF;

    typedef enum logic [STATE_W-1:0] {
        ST_NEUTRAL    = 3'd0,
        ST_DEBOUNCE   = 3'd1,
        ST_SHORT_DOWN = 3'd2,
        ST_LONG_DOWN  = 3'd3,
        ST_SHORT_UP   = 3'd4,
        ST_LONG_UP    = 3'd5
    } t_btn_state;

    typedef enum logic [1:0] {
        OP_POLL  = 2'd0,
        OP_TICK  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_QUERY = 2'd3
    } t_op;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_DEBOUNCE_TICKS = 1'b0,
        REG_LONG_FACTOR    = 1'b1
    } t_reg_index;

    typedef struct packed {
        logic [TIMER_W-1:0] debounce_ticks;
        logic [COUNT_W-1:0] long_factor;
    } t_cfg;

    // Per-button strobes for one accepted transfer.
    typedef struct packed {
        logic poll;
        logic tick;
        logic clear;
        logic pressed;
    } t_cell_ctrl;

endpackage

FILE: hw/rtl/btndb_cell.sv
// One button: state machine, saturating hold counter and countdown timer.
// Depends on btndb_pkg for the state encoding and the control structs.
module btndb_cell
    import btndb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctrl i_ctrl,
    input  t_cfg       i_cfg,
    output t_btn_state o_state,
    output t_btn_state o_next_state
);

    t_btn_state         r_state, n_state;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [TIMER_W-1:0] r_timer, n_timer;
    logic               w_eval;
    logic [COUNT_W-1:0] w_count_inc;

    assign w_eval      = i_ctrl.poll && (r_timer == '0);
    assign w_count_inc = (r_count == COUNT_MAX) ? r_count : r_count + COUNT_W'(1);

    // Next state.
    always_comb begin
        n_state = r_state;
        if (i_ctrl.clear) begin
            n_state = ST_NEUTRAL;
        end else if (w_eval) begin
            case (r_state)
                ST_NEUTRAL: begin
                    if (i_ctrl.pressed) n_state = ST_DEBOUNCE;
                end
                ST_DEBOUNCE: begin
                    n_state = i_ctrl.pressed ? ST_SHORT_DOWN : ST_NEUTRAL;
                end
                ST_SHORT_DOWN: begin
                    if (!i_ctrl.pressed) begin
                        n_state = ST_SHORT_UP;
                    end else if (w_count_inc > i_cfg.long_factor) begin
                        n_state = ST_LONG_DOWN;
                    end
                end
                ST_LONG_DOWN: begin
                    if (!i_ctrl.pressed) n_state = ST_LONG_UP;
                end
                default: n_state = r_state;
            endcase
        end
    end

    // Counter and timer updates.
    always_comb begin
        n_count = r_count;
        n_timer = r_timer;
        if (w_eval) begin
            n_timer = i_cfg.debounce_ticks;
            if (i_ctrl.pressed) begin
                case (r_state)
                    ST_NEUTRAL:    n_count = '0;
                    ST_DEBOUNCE,
                    ST_SHORT_DOWN: n_count = w_count_inc;
                    default:       n_count = r_count;
                endcase
            end
        end else if (i_ctrl.tick && (r_timer != '0)) begin
            n_timer = r_timer - TIMER_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_NEUTRAL;
            r_count <= '0;
            r_timer <= INITIAL_DELAY;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_timer <= n_timer;
        end
    end

    assign o_state      = r_state;
    assign o_next_state = n_state;

endmodule

FILE: hw/rtl/button_debounce_short_long_press_core.sv
// Top level of the push-button debouncer with short and long press detection.
// Instantiates one btndb_cell per button; depends on btndb_pkg.
//
//  channel  | direction | handshake                     | payload
//  ---------+-----------+-------------------------------+-------------------------------
//  s_axis   | in        | i_s_axis_tvalid/o_s_axis_tready | tuser op, tdata pins/idx/qs
//  m_axis   | out       | o_m_axis_tvalid/i_m_axis_tready | tdata five states, match flag
//  cfg      | in        | i_cfg_valid/o_cfg_ready       | i_cfg_index, i_cfg_data
//
// A poll or tick updates all buttons and a clear only the selected one in the cycle the
// transfer is accepted; its result reaches the output register on the next cycle: one
// item per cycle unless stalled. Input is accepted when the output register is empty or
// being drained. Synchronous active-low reset sets every button neutral, counters to
// zero and timers to the initial delay; configuration returns to its default values.
module button_debounce_short_long_press_core
    import btndb_pkg::*;
#(
    parameter int BUTTONS = 5
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // [4:0] pin_levels, [7:5] button_index, [10:8] query_state, [15:11] zero
    input  logic [15:0]            i_s_axis_tdata,
    // [1:0] op
    input  logic [1:0]             i_s_axis_tuser,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // [2:0] state_right, [5:3] state_left, [8:6] state_down, [11:9] state_up,
    // [14:12] state_press, [15] state_matches
    output logic [15:0]            o_m_axis_tdata,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    t_cfg               r_cfg;
    logic               r_out_valid;
    logic [15:0]        r_out_data;
    logic               w_accept;
    t_op                w_op;
    logic [PIN_BITS-1:0] w_pins;
    logic [IDX_W-1:0]   w_idx;
    logic [STATE_W-1:0] w_qs;
    logic [BUTTONS-1:0] w_sel;
    logic [BUTTONS-1:0] w_hit;
    t_btn_state         w_state      [BUTTONS];
    t_btn_state         w_next_state [BUTTONS];
    logic [STATE_W-1:0] w_out_state  [OUT_BUTTONS];
    logic               w_matches;

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;

    assign w_op   = t_op'(i_s_axis_tuser);
    assign w_pins = i_s_axis_tdata[4:0];
    assign w_idx  = i_s_axis_tdata[7:5];
    assign w_qs   = i_s_axis_tdata[10:8];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks <= RESET_DEBOUNCE;
            r_cfg.long_factor    <= RESET_LONG_FACTOR;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_DEBOUNCE_TICKS: r_cfg.debounce_ticks <= i_cfg_data;
                REG_LONG_FACTOR:    r_cfg.long_factor    <= i_cfg_data;
                default:            r_cfg                <= r_cfg;
            endcase
        end
    end

    for (genvar i = 0; i < BUTTONS; i++) begin : g_btn
        t_cell_ctrl w_ctrl;

        // The index is widened so that buttons beyond eight never alias.
        assign w_sel[i] = ({{(IDX_CMP_W-IDX_W){1'b0}}, w_idx} == IDX_CMP_W'(i));
        assign w_hit[i] = w_sel[i] && (STATE_W'(w_state[i]) == w_qs);

        assign w_ctrl.poll  = w_accept && (w_op == OP_POLL);
        assign w_ctrl.tick  = w_accept && (w_op == OP_TICK);
        assign w_ctrl.clear = w_accept && (w_op == OP_CLEAR) && w_sel[i];
        if (i < PIN_BITS) begin : g_pin
            assign w_ctrl.pressed = !w_pins[i];
        end else begin : g_nopin
            assign w_ctrl.pressed = 1'b0;
        end

        btndb_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl),
            .i_cfg        (r_cfg),
            .o_state      (w_state[i]),
            .o_next_state (w_next_state[i])
        );
    end

    for (genvar i = 0; i < OUT_BUTTONS; i++) begin : g_out
        if (i < BUTTONS) begin : g_have
            assign w_out_state[i] = w_next_state[i];
        end else begin : g_none
            assign w_out_state[i] = '0;
        end
    end

    assign w_matches = (w_op == OP_QUERY) && (|w_hit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_out_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data <= {w_matches, w_out_state[4], w_out_state[3], w_out_state[2],
                           w_out_state[1], w_out_state[0]};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule
